// ----- hdl/metx_pkg.sv -----
// Package for the 3x3 Taylor matrix exponential: dimension, element count and series order.
// No dependencies; used by metx_mul_stage and the top level.
package metx_pkg;

    localparam int unsigned DIM   = 3;
    localparam int unsigned ELEMS = 9;
    localparam int unsigned ORDER = 6;

endpackage

// ----- hdl/metx_mul_stage.sv -----
// One series step: next term = round((term * A) / k), sum += next term, all saturated.
// Pipelined in four register stages (products, round, divide, accumulate).
// Depends on metx_pkg.
module metx_mul_stage
    import metx_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 20,
    parameter int K          = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_vld,
    input  logic signed [DATA_WIDTH-1:0] i_a    [ELEMS],
    input  logic signed [DATA_WIDTH-1:0] i_term [ELEMS],
    input  logic signed [DATA_WIDTH-1:0] i_sum  [ELEMS],
    input  logic                         i_ov,
    output logic                         o_vld,
    output logic signed [DATA_WIDTH-1:0] o_a    [ELEMS],
    output logic signed [DATA_WIDTH-1:0] o_term [ELEMS],
    output logic signed [DATA_WIDTH-1:0] o_sum  [ELEMS],
    output logic                         o_ov
);

    localparam int PW = 2 * DATA_WIDTH + 2;
    localparam int SW = PW - FRAC_BITS;
    localparam int KW = $clog2(K + 1) + 1;
    localparam int RW = SW + KW + 1;
    localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] KD   = DATA_WIDTH'(K);
    localparam logic [DATA_WIDTH-1:0] KH   = DATA_WIDTH'(K / 2);
    localparam logic [RW-1:0]         ONER = RW'(1);
    localparam logic [RW-1:0]         RECIP =
        ((ONER << (DATA_WIDTH + 1)) + RW'(K - 1)) / RW'(K);

    logic                         r_v1, r_v2, r_v3, r_v4;
    logic signed [PW-1:0]         r_acc  [ELEMS];
    logic [DATA_WIDTH:0]          r_num  [ELEMS];
    logic                         r_ng   [ELEMS];
    logic signed [DATA_WIDTH-1:0] r_a1   [ELEMS], r_a2 [ELEMS], r_a3 [ELEMS], r_a4 [ELEMS];
    logic signed [DATA_WIDTH-1:0] r_s1   [ELEMS], r_s2 [ELEMS], r_s3 [ELEMS], r_s4 [ELEMS];
    logic signed [DATA_WIDTH-1:0] r_t3   [ELEMS], r_t4 [ELEMS];
    logic                         r_o1, r_o2, r_o3, r_o4;
    logic signed [PW-1:0]         n_acc  [ELEMS];
    logic [DATA_WIDTH:0]          n_num  [ELEMS];
    logic                         n_ng   [ELEMS];
    logic signed [DATA_WIDTH-1:0] n_t3   [ELEMS], n_s4 [ELEMS];
    logic                         n_o2, n_o4;

    always_comb begin
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                n_acc[i*DIM+j] = '0;
                for (int m = 0; m < DIM; m++) begin
                    n_acc[i*DIM+j] = n_acc[i*DIM+j]
                        + PW'(i_term[i*DIM+m] * i_a[m*DIM+j]);
                end
            end
        end
    end

    always_comb begin
        logic signed [PW-1:0]         rnd;
        logic signed [SW-1:0]         sh;
        logic signed [DATA_WIDTH-1:0] el;
        logic [DATA_WIDTH-1:0]        mag;
        n_o2 = r_o1;
        for (int e = 0; e < ELEMS; e++) begin
            rnd = r_acc[e] + (PW'(1) << (FRAC_BITS - 1));
            sh  = SW'(rnd >>> FRAC_BITS);
            if (sh > SW'(MAXV)) begin
                el = MAXV;
                n_o2 = 1'b1;
            end else if (sh < SW'(MINV)) begin
                el = MINV;
                n_o2 = 1'b1;
            end else begin
                el = DATA_WIDTH'(sh);
            end
            mag      = el[DATA_WIDTH-1] ? DATA_WIDTH'(-el) : DATA_WIDTH'(el);
            n_num[e] = {1'b0, mag} + {1'b0, KH};
            n_ng[e]  = el[DATA_WIDTH-1];
        end
    end

    always_comb begin
        logic [2*RW-1:0]              prod;
        logic [DATA_WIDTH:0]          q;
        logic [DATA_WIDTH+1:0]        rem;
        for (int e = 0; e < ELEMS; e++) begin
            prod = (2*RW)'(RW'(r_num[e])) * (2*RW)'(RECIP);
            q    = (DATA_WIDTH+1)'(prod >> (DATA_WIDTH + 1));
            rem  = (DATA_WIDTH+2)'(r_num[e]) - (DATA_WIDTH+2)'(q) * (DATA_WIDTH+2)'(KD);
            if (rem[DATA_WIDTH+1]) q = q - 1'b1;
            n_t3[e] = r_ng[e] ? DATA_WIDTH'(-q) : DATA_WIDTH'(q);
        end
    end

    always_comb begin
        logic signed [DATA_WIDTH:0] s;
        n_o4 = r_o3;
        for (int e = 0; e < ELEMS; e++) begin
            s = (DATA_WIDTH+1)'(r_s3[e]) + (DATA_WIDTH+1)'(r_t3[e]);
            if (s > (DATA_WIDTH+1)'(MAXV)) begin
                n_s4[e] = MAXV;
                n_o4 = 1'b1;
            end else if (s < (DATA_WIDTH+1)'(MINV)) begin
                n_s4[e] = MINV;
                n_o4 = 1'b1;
            end else begin
                n_s4[e] = DATA_WIDTH'(s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_acc <= n_acc;
            r_a1  <= i_a;
            r_s1  <= i_sum;
            r_o1  <= i_ov;
            r_num <= n_num;
            r_ng  <= n_ng;
            r_a2  <= r_a1;
            r_s2  <= r_s1;
            r_o2  <= n_o2;
            r_a3  <= r_a2;
            r_s3  <= r_s2;
            r_t3  <= n_t3;
            r_o3  <= r_o2;
            r_a4  <= r_a3;
            r_s4  <= n_s4;
            r_t4  <= r_t3;
            r_o4  <= n_o4;
        end
    end

    assign o_vld  = r_v4;
    assign o_a    = r_a4;
    assign o_term = r_t4;
    assign o_sum  = r_s4;
    assign o_ov   = r_o4;

    a_ov_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && r_o3 |=> r_o4) else $error("overflow dropped");
    a_vld_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_v4)) else $error("valid moved in stall");
    a_vld_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv |=> r_v2 == $past(r_v1)) else $error("valid lost");

endmodule

// ----- hdl/matrix_exponential_taylor_3x3.sv -----
// Structure: an input stage plus five series steps of four stages each.
// Throughput: one item per cycle; the whole pipeline holds while o_valid and i_stall.
// Reset: synchronous active-low i_rst_n clears all valid bits; data is not reset.
// Depends on metx_pkg and metx_mul_stage.
module matrix_exponential_taylor_3x3
    import metx_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_WIDTH-1:0] i_in_r0c0, i_in_r0c1, i_in_r0c2,
    input  logic signed [DATA_WIDTH-1:0] i_in_r1c0, i_in_r1c1, i_in_r1c2,
    input  logic signed [DATA_WIDTH-1:0] i_in_r2c0, i_in_r2c1, i_in_r2c2,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_out_r0c0, o_out_r0c1, o_out_r0c2,
    output logic signed [DATA_WIDTH-1:0] o_out_r1c0, o_out_r1c1, o_out_r1c2,
    output logic signed [DATA_WIDTH-1:0] o_out_r2c0, o_out_r2c1, o_out_r2c2,
    output logic                         o_overflow_flag
);

    localparam int NSTEP = ORDER - 1;
    localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam bit ONE_OV = (FRAC_BITS >= DATA_WIDTH - 1);
    localparam logic signed [DATA_WIDTH-1:0] ONEV =
        ONE_OV ? MAXV : DATA_WIDTH'(64'd1 << FRAC_BITS);

    logic                         adv;
    logic signed [DATA_WIDTH-1:0] in_a [ELEMS];
    logic signed [DATA_WIDTH-1:0] n_sum [ELEMS];
    logic                         n_ov;
    logic                         st_vld  [NSTEP+1];
    logic signed [DATA_WIDTH-1:0] st_a    [NSTEP+1][ELEMS];
    logic signed [DATA_WIDTH-1:0] st_term [NSTEP+1][ELEMS];
    logic signed [DATA_WIDTH-1:0] st_sum  [NSTEP+1][ELEMS];
    logic                         st_ov   [NSTEP+1];
    logic                         r_v0;
    logic signed [DATA_WIDTH-1:0] r_a0 [ELEMS], r_s0 [ELEMS];
    logic                         r_o0;

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    assign in_a = '{i_in_r0c0, i_in_r0c1, i_in_r0c2, i_in_r1c0, i_in_r1c1,
                    i_in_r1c2, i_in_r2c0, i_in_r2c1, i_in_r2c2};

    always_comb begin
        logic signed [DATA_WIDTH:0] s;
        n_ov = ONE_OV;
        for (int e = 0; e < ELEMS; e++) begin
            s = (DATA_WIDTH+1)'(in_a[e]) + ((e % 4 == 0) ? (DATA_WIDTH+1)'(ONEV) : '0);
            if (s > (DATA_WIDTH+1)'(MAXV)) begin
                n_sum[e] = MAXV;
                n_ov = 1'b1;
            end else if (s < (DATA_WIDTH+1)'(MINV)) begin
                n_sum[e] = MINV;
                n_ov = 1'b1;
            end else begin
                n_sum[e] = DATA_WIDTH'(s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a0 <= in_a;
            r_s0 <= n_sum;
            r_o0 <= n_ov;
        end
    end

    assign st_vld[0]  = r_v0;
    assign st_a[0]    = r_a0;
    assign st_term[0] = r_a0;
    assign st_sum[0]  = r_s0;
    assign st_ov[0]   = r_o0;

    for (genvar g = 0; g < NSTEP; g++) begin : g_step
        metx_mul_stage #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .K          (g + 2)
        ) u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (adv),
            .i_vld  (st_vld[g]),
            .i_a    (st_a[g]),
            .i_term (st_term[g]),
            .i_sum  (st_sum[g]),
            .i_ov   (st_ov[g]),
            .o_vld  (st_vld[g+1]),
            .o_a    (st_a[g+1]),
            .o_term (st_term[g+1]),
            .o_sum  (st_sum[g+1]),
            .o_ov   (st_ov[g+1])
        );
    end

    assign o_valid         = st_vld[NSTEP];
    assign o_overflow_flag = st_ov[NSTEP];
    assign o_out_r0c0 = st_sum[NSTEP][0];
    assign o_out_r0c1 = st_sum[NSTEP][1];
    assign o_out_r0c2 = st_sum[NSTEP][2];
    assign o_out_r1c0 = st_sum[NSTEP][3];
    assign o_out_r1c1 = st_sum[NSTEP][4];
    assign o_out_r1c2 = st_sum[NSTEP][5];
    assign o_out_r2c0 = st_sum[NSTEP][6];
    assign o_out_r2c1 = st_sum[NSTEP][7];
    assign o_out_r2c2 = st_sum[NSTEP][8];

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_r1c1)) else $error("output moved");
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall)) else $error("bad stall");
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_v0 == $past(i_valid)) else $error("input valid lost");

endmodule

// ----- tb/sv/matrix_exponential_taylor_3x3_test.sv -----
// Self-checking testbench for the 3x3 Taylor-series matrix exponential.
// Depends on metx_pkg and matrix_exponential_taylor_3x3; it drives random
// and edge-case matrices and checks each result against its own model.
module matrix_exponential_taylor_3x3_test;
    import metx_pkg::*;

    localparam int DW        = 32;
    localparam int FB        = 20;
    localparam int MAT_BITS  = ELEMS * DW;
    localparam int WATCHDOG  = 20000;
    localparam int HOLD_LEN  = 400;
    localparam longint EL_MAX = 64'sd2147483647;
    localparam longint EL_MIN = -64'sd2147483648;

    typedef logic [MAT_BITS-1:0] mat_t;
    typedef struct packed {
        mat_t m;
        logic ov;
    } expm_t;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall, o_overflow_flag;
    logic signed [DW-1:0] i_in [ELEMS];
    logic signed [DW-1:0] o_out [ELEMS];

    mat_t   pending_q[$];
    expm_t  expm_q[$];
    logic   took;
    logic   failed;
    int     idle_cnt;
    int     cycle_cnt;
    int     sent_cnt;

    matrix_exponential_taylor_3x3 DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_in_r0c0(i_in[0]), .i_in_r0c1(i_in[1]), .i_in_r0c2(i_in[2]),
        .i_in_r1c0(i_in[3]), .i_in_r1c1(i_in[4]), .i_in_r1c2(i_in[5]),
        .i_in_r2c0(i_in[6]), .i_in_r2c1(i_in[7]), .i_in_r2c2(i_in[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_r0c0(o_out[0]), .o_out_r0c1(o_out[1]), .o_out_r0c2(o_out[2]),
        .o_out_r1c0(o_out[3]), .o_out_r1c1(o_out[4]), .o_out_r1c2(o_out[5]),
        .o_out_r2c0(o_out[6]), .o_out_r2c1(o_out[7]), .o_out_r2c2(o_out[8]),
        .o_overflow_flag(o_overflow_flag)
    );

    function automatic longint clamp_el(longint x, inout logic ov);
        if (x > EL_MAX) begin
            ov = 1'b1;
            return EL_MAX;
        end
        if (x < EL_MIN) begin
            ov = 1'b1;
            return EL_MIN;
        end
        return x;
    endfunction

    function automatic longint div_nearest(longint x, longint k);
        longint mag;
        longint q;
        mag = (x < 0) ? -x : x;
        q = (mag + k / 2) / k;
        return (x < 0) ? -q : q;
    endfunction

    function automatic expm_t taylor_expm(mat_t m);
        longint a[ELEMS], term[ELEMS], nxt[ELEMS], sum[ELEMS];
        logic signed [127:0] acc, x, y, v;
        logic ov;
        expm_t r;
        ov = 1'b0;
        for (int i = 0; i < ELEMS; i++) begin
            a[i] = longint'($signed(m[i*DW +: DW]));
            term[i] = a[i];
            sum[i] = clamp_el(((i % 4 == 0) ? (64'sd1 <<< FB) : 64'sd0) + a[i], ov);
        end
        for (int k = 2; k <= ORDER; k++) begin
            for (int i = 0; i < DIM; i++) begin
                for (int j = 0; j < DIM; j++) begin
                    acc = '0;
                    for (int n = 0; n < DIM; n++) begin
                        x = 128'(term[i*DIM+n]);
                        y = 128'(a[n*DIM+j]);
                        acc = acc + x * y;
                    end
                    v = (acc + (128'sd1 <<< (FB - 1))) >>> FB;
                    if (v > 128'(EL_MAX)) begin
                        ov = 1'b1;
                        nxt[i*DIM+j] = EL_MAX;
                    end else if (v < 128'(EL_MIN)) begin
                        ov = 1'b1;
                        nxt[i*DIM+j] = EL_MIN;
                    end else begin
                        nxt[i*DIM+j] = longint'(v);
                    end
                end
            end
            for (int i = 0; i < ELEMS; i++) begin
                term[i] = div_nearest(nxt[i], k);
                sum[i] = clamp_el(sum[i] + term[i], ov);
            end
        end
        for (int i = 0; i < ELEMS; i++) r.m[i*DW +: DW] = sum[i][DW-1:0];
        r.ov = ov;
        return r;
    endfunction

    function automatic logic [DW-1:0] rand_el(int mode);
        logic [DW-1:0] v;
        v = $urandom;
        case (mode)
            0: v = DW'($signed($urandom_range(0, 32'h0018_0000)) - 32'sh000C_0000);
            1: v = DW'($signed($urandom_range(0, 32'h0060_0000)) - 32'sh0030_0000);
            default: ;
        endcase
        return v;
    endfunction

    function automatic mat_t fill_mat(logic [DW-1:0] d, logic [DW-1:0] o);
        mat_t m;
        for (int i = 0; i < ELEMS; i++) m[i*DW +: DW] = (i % 4 == 0) ? d : o;
        return m;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        mat_t m;
        int mode;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        for (int i = 0; i < ELEMS; i++) i_in[i] = '0;
        pending_q.push_back(fill_mat(32'h0, 32'h0));
        pending_q.push_back(fill_mat(32'h0010_0000, 32'h0));
        pending_q.push_back(fill_mat(32'hFFF0_0000, 32'h0));
        pending_q.push_back(fill_mat(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_q.push_back(fill_mat(32'h8000_0000, 32'h8000_0000));
        pending_q.push_back(fill_mat(32'h7FFF_FFFF, 32'h8000_0000));
        pending_q.push_back(fill_mat(32'h8000_0000, 32'h7FFF_FFFF));
        pending_q.push_back(fill_mat(32'h0000_0001, 32'hFFFF_FFFF));
        pending_q.push_back(fill_mat(32'h0, 32'h0008_0000));
        pending_q.push_back(fill_mat(32'h0040_0000, 32'hFFE0_0000));
        pending_q.push_back(fill_mat(32'h0200_0000, 32'h0));
        pending_q.push_back(fill_mat(32'hF800_0000, 32'h0));
        m = '0;
        m[1*DW +: DW] = 32'h0010_0000;
        m[3*DW +: DW] = 32'hFFF0_0000;
        pending_q.push_back(m);
        m = '0;
        m[1*DW +: DW] = 32'h0010_0000;
        m[5*DW +: DW] = 32'h0010_0000;
        pending_q.push_back(m);
        m = '0;
        m[8*DW +: DW] = 32'h0000_0003;
        m[0] = 1'b1;
        pending_q.push_back(m);
        for (int n = 0; n < 1100; n++) begin
            mode = $urandom_range(0, 9);
            mode = (mode < 6) ? 0 : (mode < 8) ? 1 : 2;
            for (int i = 0; i < ELEMS; i++) m[i*DW +: DW] = rand_el(mode);
            pending_q.push_back(m);
        end
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (pending_q.size() == 0 && !i_valid && expm_q.size() == 0);
        repeat (40) @(posedge i_clk);
        if (!failed && expm_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || took) begin
                if (pending_q.size() != 0 &&
                    ((sent_cnt > 300 && sent_cnt < 500) || $urandom_range(0, 99) >= 26)) begin
                    mat_t m;
                    m = pending_q.pop_front();
                    for (int i = 0; i < ELEMS; i++) i_in[i] <= m[i*DW +: DW];
                    i_valid <= 1'b1;
                    sent_cnt <= sent_cnt + 1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            cycle_cnt <= cycle_cnt + 1;
            if (cycle_cnt >= 1000 && cycle_cnt < 1000 + HOLD_LEN)
                i_stall <= 1'b1;
            else if (cycle_cnt >= 4000 && cycle_cnt < 4300)
                i_stall <= 1'b0;
            else
                i_stall <= ($urandom_range(0, 99) < 26);
        end
    end

    always @(posedge i_clk) begin
        took <= i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            mat_t m;
            for (int i = 0; i < ELEMS; i++) m[i*DW +: DW] = i_in[i];
            expm_q.push_back(taylor_expm(m));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            expm_t e;
            if (expm_q.size() == 0) begin
                $error("result with no item pending");
                failed = 1'b1;
            end else begin
                e = expm_q.pop_front();
                for (int i = 0; i < ELEMS; i++) begin
                    if (o_out[i] !== e.m[i*DW +: DW]) begin
                        $error("out_r%0dc%0d expected %0d actual %0d", i / DIM, i % DIM,
                               $signed(e.m[i*DW +: DW]), o_out[i]);
                        failed = 1'b1;
                    end
                end
                if (o_overflow_flag !== e.ov) begin
                    $error("overflow_flag expected %0b actual %0b", e.ov, o_overflow_flag);
                    failed = 1'b1;
                end
            end
        end
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WATCHDOG) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        took = 1'b0;
        failed = 1'b0;
        idle_cnt = 0;
        cycle_cnt = 0;
        sent_cnt = 0;
    end

endmodule

// ----- matrix_exponential_taylor_3x3.f -----
hdl/metx_pkg.sv
hdl/metx_mul_stage.sv
hdl/matrix_exponential_taylor_3x3.sv
tb/sv/matrix_exponential_taylor_3x3_test.sv
